FILE: rtl/sci_pkg.sv
package sci_pkg;

  // Field widths
  localparam int CoordBits  = 16;
  localparam int RadiusBits = 15;

  // Stream payload layout
  localparam int RadiusLsb = 6 * CoordBits;
  localparam int InW       = 6 * CoordBits + RadiusBits;
  localparam int InDataW   = ((InW + 7) / 8) * 8;
  localparam int OutDataW  = 8;

  // Datapath widths: differences, products, squared magnitudes
  localparam int DiffW = CoordBits + 1;
  localparam int ProdW = 2 * DiffW;
  localparam int R2W   = 2 * RadiusBits;
  localparam int MagW  = 2 * CoordBits + 1;
  localparam int DistW = (ProdW > R2W) ? ProdW : R2W;

  // Split of the cross term and of |D|^2 into two halves for the final products
  localparam int HalfW = (MagW + 1) / 2;
  localparam int HiW   = MagW - HalfW;
  localparam int LeftW  = 2 * MagW;
  localparam int RightW = R2W + MagW;
  localparam int CmpW   = (LeftW > RightW) ? LeftW : RightW;

  // Control that rides along with the cross-term compare
  typedef struct packed {
    logic valid;
    logic use_cross;
    logic near_hit;
  } sci_ctl_t;

endpackage

FILE: rtl/segment_circle_intersection_unit.sv
// Segment versus closed disk hit test, fully pipelined.
// Throughput: one request per cycle; each stage holds when the next one is full,
// so a stalled result does not block new requests until all seven stages fill.
// Reset (rst_ni low, asynchronous) clears every stage valid bit; data is not reset.
module segment_circle_intersection_unit
  import sci_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // start_x, start_y, end_x, end_y, center_x, center_y, radius, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // hit, zero pad
  output logic [OutDataW-1:0] m_axis_tdata_o
);

  // Stage valid bits and ready chain
  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_cmp;

  assign rdy4 = !v4_q || rdy_cmp;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign s_axis_tready_o = rdy1;

  // Unpack the request
  logic signed [CoordBits-1:0] sx, sy, ex, ey, cx, cy;
  logic [RadiusBits-1:0]       rad;

  assign sx  = s_axis_tdata_i[0 * CoordBits +: CoordBits];
  assign sy  = s_axis_tdata_i[1 * CoordBits +: CoordBits];
  assign ex  = s_axis_tdata_i[2 * CoordBits +: CoordBits];
  assign ey  = s_axis_tdata_i[3 * CoordBits +: CoordBits];
  assign cx  = s_axis_tdata_i[4 * CoordBits +: CoordBits];
  assign cy  = s_axis_tdata_i[5 * CoordBits +: CoordBits];
  assign rad = s_axis_tdata_i[RadiusLsb +: RadiusBits];

  // Stage 1: D = end - start, F = start - center, G = end - center
  logic signed [DiffW-1:0] dx_d, dy_d, fx_d, fy_d, gx_d, gy_d;
  logic signed [DiffW-1:0] dx_q, dy_q, fx_q, fy_q, gx_q, gy_q;
  logic [RadiusBits-1:0]   rad_q;

  assign dx_d = DiffW'(ex) - DiffW'(sx);
  assign dy_d = DiffW'(ey) - DiffW'(sy);
  assign fx_d = DiffW'(sx) - DiffW'(cx);
  assign fy_d = DiffW'(sy) - DiffW'(cy);
  assign gx_d = DiffW'(ex) - DiffW'(cx);
  assign gy_d = DiffW'(ey) - DiffW'(cy);

  // Stage 2: products of the differences, and r^2
  logic signed [ProdW-1:0] dxdx_d, dydy_d, fxdx_d, fydy_d, fxfx_d, fyfy_d;
  logic signed [ProdW-1:0] gxgx_d, gygy_d, fxdy_d, fydx_d;
  logic signed [ProdW-1:0] dxdx_q, dydy_q, fxdx_q, fydy_q, fxfx_q, fyfy_q;
  logic signed [ProdW-1:0] gxgx_q, gygy_q, fxdy_q, fydx_q;
  logic [R2W-1:0]          r2_d, r2_q2;

  assign dxdx_d = ProdW'(dx_q) * ProdW'(dx_q);
  assign dydy_d = ProdW'(dy_q) * ProdW'(dy_q);
  assign fxdx_d = ProdW'(fx_q) * ProdW'(dx_q);
  assign fydy_d = ProdW'(fy_q) * ProdW'(dy_q);
  assign fxfx_d = ProdW'(fx_q) * ProdW'(fx_q);
  assign fyfy_d = ProdW'(fy_q) * ProdW'(fy_q);
  assign gxgx_d = ProdW'(gx_q) * ProdW'(gx_q);
  assign gygy_d = ProdW'(gy_q) * ProdW'(gy_q);
  assign fxdy_d = ProdW'(fx_q) * ProdW'(dy_q);
  assign fydx_d = ProdW'(fy_q) * ProdW'(dx_q);
  assign r2_d   = R2W'(rad_q) * R2W'(rad_q);

  // Stage 3: |D|^2, F.D, |F|^2, |G|^2, F x D
  logic signed [ProdW-1:0] len2_d, fd_d, f2_d, g2_d, crs_d;
  logic signed [ProdW-1:0] len2_q, fd_q, f2_q, g2_q, crs_q;
  logic [R2W-1:0]          r2_q3;

  assign len2_d = dxdx_q + dydy_q;
  assign fd_d   = fxdx_q + fydy_q;
  assign f2_d   = fxfx_q + fyfy_q;
  assign g2_d   = gxgx_q + gygy_q;
  assign crs_d  = fxdy_q - fydx_q;

  // Stage 4: pick the nearest-point case, endpoint distance tests
  logic signed [ProdW:0]   fd_plus_len;
  logic signed [ProdW-1:0] crs_neg;
  logic                    start_near, end_near, use_cross_d, near_hit_d;
  logic [MagW-1:0]         cr_d, cr_q, len2m_q;
  logic [R2W-1:0]          r2_q4;
  logic                    use_cross_q, near_hit_q;

  assign fd_plus_len = (ProdW + 1)'(fd_q) + (ProdW + 1)'(len2_q);
  assign start_near  = !fd_q[ProdW-1];
  assign end_near    = fd_plus_len[ProdW] || (fd_plus_len == '0);
  assign use_cross_d = !start_near && !end_near;
  assign near_hit_d  = start_near ? (DistW'(unsigned'(f2_q)) <= DistW'(r2_q3))
                                  : (DistW'(unsigned'(g2_q)) <= DistW'(r2_q3));
  assign crs_neg     = -crs_q;
  assign cr_d        = crs_q[ProdW-1] ? crs_neg[MagW-1:0] : crs_q[MagW-1:0];

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1 && s_axis_tvalid_i) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      fx_q  <= fx_d;
      fy_q  <= fy_d;
      gx_q  <= gx_d;
      gy_q  <= gy_d;
      rad_q <= rad;
    end
    if (rdy2 && v1_q) begin
      dxdx_q <= dxdx_d;
      dydy_q <= dydy_d;
      fxdx_q <= fxdx_d;
      fydy_q <= fydy_d;
      fxfx_q <= fxfx_d;
      fyfy_q <= fyfy_d;
      gxgx_q <= gxgx_d;
      gygy_q <= gygy_d;
      fxdy_q <= fxdy_d;
      fydx_q <= fydx_d;
      r2_q2  <= r2_d;
    end
    if (rdy3 && v2_q) begin
      len2_q <= len2_d;
      fd_q   <= fd_d;
      f2_q   <= f2_d;
      g2_q   <= g2_d;
      crs_q  <= crs_d;
      r2_q3  <= r2_q2;
    end
    if (rdy4 && v3_q) begin
      use_cross_q <= use_cross_d;
      near_hit_q  <= near_hit_d;
      cr_q        <= cr_d;
      len2m_q     <= len2_q[MagW-1:0];
      r2_q4       <= r2_q3;
    end
  end

  // Stages 5 to 7: (F x D)^2 <= r^2 * |D|^2 and final select
  sci_ctl_t cmp_ctl;
  logic     hit;

  assign cmp_ctl.valid     = v4_q;
  assign cmp_ctl.use_cross = use_cross_q;
  assign cmp_ctl.near_hit  = near_hit_q;

  sci_cross_cmp u_cross_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (cmp_ctl),
    .cr_i    (cr_q),
    .len2_i  (len2m_q),
    .r2_i    (r2_q4),
    .ready_o (rdy_cmp),
    .valid_o (m_axis_tvalid_o),
    .hit_o   (hit),
    .ready_i (m_axis_tready_i)
  );

  assign m_axis_tdata_o = OutDataW'(hit);

endmodule

FILE: rtl/sci_cross_cmp.sv
module sci_cross_cmp
  import sci_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sci_ctl_t          ctl_i,
  input  logic [MagW-1:0]   cr_i,
  input  logic [MagW-1:0]   len2_i,
  input  logic [R2W-1:0]    r2_i,
  output logic              ready_o,
  output logic              valid_o,
  output logic              hit_o,
  input  logic              ready_i
);

  localparam int HhW = 2 * HiW;
  localparam int HlW = HiW + HalfW;
  localparam int LlW = 2 * HalfW;
  localparam int RhW = R2W + HiW;
  localparam int RlW = R2W + HalfW;

  // Stage valid bits and ready chain
  logic v5_q, v6_q, v7_q;
  logic rdy5, rdy6, rdy7;

  assign rdy7    = !v7_q || ready_i;
  assign rdy6    = !v6_q || rdy7;
  assign rdy5    = !v5_q || rdy6;
  assign ready_o = rdy5;

  // Stage 5: partial products of cr^2 and r^2 * |D|^2
  logic [HiW-1:0]   cr_hi, len_hi;
  logic [HalfW-1:0] cr_lo, len_lo;
  logic [HhW-1:0]   hh_d, hh_q;
  logic [HlW-1:0]   hl_d, hl_q;
  logic [LlW-1:0]   ll_d, ll_q;
  logic [RhW-1:0]   rh_d, rh_q;
  logic [RlW-1:0]   rl_d, rl_q;
  logic             use5_q, near5_q;

  assign cr_hi  = cr_i[MagW-1:HalfW];
  assign cr_lo  = cr_i[HalfW-1:0];
  assign len_hi = len2_i[MagW-1:HalfW];
  assign len_lo = len2_i[HalfW-1:0];

  assign hh_d = HhW'(cr_hi) * HhW'(cr_hi);
  assign hl_d = HlW'(cr_hi) * HlW'(cr_lo);
  assign ll_d = LlW'(cr_lo) * LlW'(cr_lo);
  assign rh_d = RhW'(r2_i) * RhW'(len_hi);
  assign rl_d = RlW'(r2_i) * RlW'(len_lo);

  // Stage 6: reassemble both sides
  logic [CmpW-1:0] left_d, left_q, right_d, right_q;
  logic            use6_q, near6_q;

  assign left_d  = (CmpW'(hh_q) << (2 * HalfW)) + (CmpW'(hl_q) << (HalfW + 1))
                 + CmpW'(ll_q);
  assign right_d = (CmpW'(rh_q) << HalfW) + CmpW'(rl_q);

  // Stage 7: final decision, also the output register
  logic hit_d, hit_q;

  assign hit_d = use6_q ? (left_q <= right_q) : near6_q;

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      if (rdy5) v5_q <= ctl_i.valid;
      if (rdy6) v6_q <= v5_q;
      if (rdy7) v7_q <= v6_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy5 && ctl_i.valid) begin
      hh_q    <= hh_d;
      hl_q    <= hl_d;
      ll_q    <= ll_d;
      rh_q    <= rh_d;
      rl_q    <= rl_d;
      use5_q  <= ctl_i.use_cross;
      near5_q <= ctl_i.near_hit;
    end
    if (rdy6 && v5_q) begin
      left_q  <= left_d;
      right_q <= right_d;
      use6_q  <= use5_q;
      near6_q <= near5_q;
    end
    if (rdy7 && v6_q) begin
      hit_q <= hit_d;
    end
  end

  assign valid_o = v7_q;
  assign hit_o   = hit_q;

endmodule

FILE: rtl/sci_checker.sv
module sci_checker
  import sci_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid_i,
  input logic                s_axis_tready_o,
  input logic [InDataW-1:0]  s_axis_tdata_i,
  input logic                m_axis_tvalid_o,
  input logic                m_axis_tready_i,
  input logic [OutDataW-1:0] m_axis_tdata_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Once the output drains, the whole pipeline can take a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tready_i || !m_axis_tvalid_o) |-> s_axis_tready_o)
    else $error("request blocked with output free");

  // Nothing comes out right after reset
  assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result valid right after reset");

endmodule

bind segment_circle_intersection_unit sci_checker u_sci_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

FILE: dv/segment_circle_intersection_unit_tb.sv
`timescale 1ns / 1ps

module segment_circle_intersection_unit_tb;
  import sci_pkg::*;

  localparam int RequestCount = 1750;
  localparam int PressureCount = 40;
  localparam int CalmFirst = 600;
  localparam int CalmLast = 1000;
  localparam int HoldCycles = 300;
  localparam int DrainCycles = 20;
  localparam int CycleLimit = 400000;
  localparam int IdlePct = 8;
  localparam int MaxReports = 40;
  localparam int CoordMax = (1 << (CoordBits - 1)) - 1;
  localparam int CoordMin = -CoordMax - 1;

  // One request: segment end points and circle
  typedef struct {
    logic signed [CoordBits-1:0] start_x;
    logic signed [CoordBits-1:0] start_y;
    logic signed [CoordBits-1:0] end_x;
    logic signed [CoordBits-1:0] end_y;
    logic signed [CoordBits-1:0] center_x;
    logic signed [CoordBits-1:0] center_y;
    logic [RadiusBits-1:0] radius;
  } seg_req_t;

  typedef struct {
    seg_req_t req;
    bit hit;
  } hit_expect_t;

  // Expected hit flags in request order, checked against the master side
  class hit_scoreboard;
    hit_expect_t pending[$];
    int errors;
    int reports;

    // Exact nearest-point distance test against the closed disk
    function bit predict_hit(seg_req_t q);
      longint sx, sy, ex, ey, cx, cy;
      longint dx, dy, fx, fy, gx, gy, len2, fd, cr, d2;
      longint unsigned r2;
      logic [127:0] lhs, rhs, len2_w;
      sx = q.start_x;
      sy = q.start_y;
      ex = q.end_x;
      ey = q.end_y;
      cx = q.center_x;
      cy = q.center_y;
      r2 = longint'(q.radius) * longint'(q.radius);
      dx = ex - sx;
      dy = ey - sy;
      fx = sx - cx;
      fy = sy - cy;
      len2 = dx * dx + dy * dy;
      fd = fx * dx + fy * dy;
      // start point nearest (also covers a zero-length segment)
      if (fd >= 0) begin
        d2 = fx * fx + fy * fy;
        return longint'(d2) <= longint'(r2);
      end
      // end point nearest
      if (fd + len2 <= 0) begin
        gx = ex - cx;
        gy = ey - cy;
        d2 = gx * gx + gy * gy;
        return longint'(d2) <= longint'(r2);
      end
      // interior point nearest: cross^2 <= r^2 * |D|^2
      cr = fx * dy - fy * dx;
      if (cr < 0) cr = -cr;
      lhs = cr;
      lhs = lhs * lhs;
      rhs = r2;
      len2_w = len2;
      rhs = rhs * len2_w;
      return lhs <= rhs;
    endfunction

    function void note_request(seg_req_t q);
      hit_expect_t item;
      item.req = q;
      item.hit = predict_hit(q);
      pending.push_back(item);
    endfunction

    function void check_result(logic [OutDataW-1:0] data);
      hit_expect_t oldest;
      if (pending.size() == 0) begin
        errors++;
        if (reports < MaxReports) begin
          reports++;
          $display("%0t: unexpected result, expected none, actual hit %0b", $time, data[0]);
        end
        return;
      end
      oldest = pending.pop_front();
      if (data[0] !== oldest.hit) begin
        errors++;
        if (reports < MaxReports) begin
          reports++;
          $display("%0t: hit expected %0b actual %0b  s=(%0d,%0d) e=(%0d,%0d) c=(%0d,%0d) r=%0d",
                   $time, oldest.hit, data[0], oldest.req.start_x, oldest.req.start_y,
                   oldest.req.end_x, oldest.req.end_y, oldest.req.center_x,
                   oldest.req.center_y, oldest.req.radius);
        end
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic [InDataW-1:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic s_axis_tready_o;
  logic m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;

  int tx_idle_pct = IdlePct;
  int rx_idle_pct = IdlePct;
  bit rx_hold_req = 1'b0;
  int cycle_count = 0;

  hit_scoreboard sb = new;

  segment_circle_intersection_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result check on every accepted result
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready) sb.check_result(m_axis_tdata_o);
  end

  // Receiver: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_req) begin
        hold_left = HoldCycles;
        rx_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  function automatic logic signed [CoordBits-1:0] to_coord(int v);
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return v[CoordBits-1:0];
  endfunction

  function automatic int spread(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic int any_coord();
    return int'($urandom_range(0, 2 * CoordMax + 1)) + CoordMin;
  endfunction

  function automatic logic signed [CoordBits-1:0] extreme_coord();
    case ($urandom_range(4))
      0: return CoordMin[CoordBits-1:0];
      1: return CoordMax[CoordBits-1:0];
      2: return '0;
      3: return '1;
      default: return CoordBits'($urandom());
    endcase
  endfunction

  function automatic seg_req_t mk(int sx, int sy, int ex, int ey, int cx, int cy, int r);
    seg_req_t q;
    q.start_x = to_coord(sx);
    q.start_y = to_coord(sy);
    q.end_x = to_coord(ex);
    q.end_y = to_coord(ey);
    q.center_x = to_coord(cx);
    q.center_y = to_coord(cy);
    q.radius = RadiusBits'(r);
    return q;
  endfunction

  function automatic logic [InDataW-1:0] pack_request(seg_req_t q);
    logic [InDataW-1:0] word;
    word = '0;
    word[InW-1:0] = {q.radius, q.center_y, q.center_x, q.end_y, q.end_x, q.start_y, q.start_x};
    return word;
  endfunction

  // Random request, mixed between wide, local, near-tangent, point, tiny and extreme-value cases
  function automatic seg_req_t random_request();
    seg_req_t q;
    int pick, cx, cy, r, off, a1, a2;
    pick = $urandom_range(99);
    cx = any_coord();
    cy = any_coord();
    if (pick < 15) begin
      // full-range fields
      q.start_x = CoordBits'($urandom());
      q.start_y = CoordBits'($urandom());
      q.end_x = CoordBits'($urandom());
      q.end_y = CoordBits'($urandom());
      q.center_x = CoordBits'($urandom());
      q.center_y = CoordBits'($urandom());
      q.radius = RadiusBits'($urandom());
    end else if (pick < 45) begin
      // segment around the circle
      r = ($urandom_range(9) == 0) ? $urandom_range(0, CoordMax) : $urandom_range(0, 2000);
      q = mk(cx + spread(2 * r + 8), cy + spread(2 * r + 8), cx + spread(2 * r + 8),
             cy + spread(2 * r + 8), cx, cy, r);
    end else if (pick < 65) begin
      // axis-aligned segment at distance r-1, r or r+1 from the center
      r = $urandom_range(0, 3000);
      cx = int'($urandom_range(0, 56000)) - 28000;
      cy = int'($urandom_range(0, 56000)) - 28000;
      off = r + int'($urandom_range(0, 2)) - 1;
      if (off < 0) off = 0;
      if ($urandom_range(1)) off = -off;
      a1 = spread(4000);
      a2 = spread(4000);
      if ($urandom_range(1)) q = mk(cx + a1, cy + off, cx + a2, cy + off, cx, cy, r);
      else q = mk(cx + off, cy + a1, cx + off, cy + a2, cx, cy, r);
    end else if (pick < 75) begin
      // zero-length segment
      r = $urandom_range(0, 3000);
      a1 = cx + spread(r + 2);
      a2 = cy + spread(r + 2);
      q = mk(a1, a2, a1, a2, cx, cy, r);
    end else if (pick < 90) begin
      // tiny geometry, many exact boundary cases
      q = mk(cx + spread(8), cy + spread(8), cx + spread(8), cy + spread(8), cx, cy,
             $urandom_range(0, 8));
    end else begin
      q.start_x = extreme_coord();
      q.start_y = extreme_coord();
      q.end_x = extreme_coord();
      q.end_y = extreme_coord();
      q.center_x = extreme_coord();
      q.center_y = extreme_coord();
      case ($urandom_range(2))
        0: q.radius = '0;
        1: q.radius = '1;
        default: q.radius = RadiusBits'($urandom());
      endcase
    end
    return q;
  endfunction

  // Offer one request, optionally with valid dropped before it, and wait for acceptance
  task automatic send_request(seg_req_t q);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct) gap = 1;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tdata <= pack_request(q);
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(q);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  task automatic run_directed();
    send_request(mk(0, 0, 0, 0, 0, 0, 0));          // point at center, radius zero
    send_request(mk(1, 0, 1, 0, 0, 0, 0));
    send_request(mk(3, 4, 3, 4, 0, 0, 5));          // point on the circle
    send_request(mk(3, 4, 3, 4, 0, 0, 4));
    send_request(mk(-10, 5, 10, 5, 0, 0, 5));       // tangent
    send_request(mk(-10, 5, 10, 5, 0, 0, 4));
    send_request(mk(-1, 7, 7, 1, 0, 0, 5));         // diagonal tangent at (3,4)
    send_request(mk(-1, 7, 7, 1, 0, 0, 4));
    send_request(mk(-3, 0, 3, 0, 0, 0, 0));         // through center, radius zero
    send_request(mk(-3, 1, 3, 1, 0, 0, 0));
    send_request(mk(5, 0, 10, 0, 0, 0, 5));         // start point nearest
    send_request(mk(10, 0, 5, 0, 0, 0, 5));         // end point nearest
    send_request(mk(10, 0, 6, 0, 0, 0, 5));
    send_request(mk(1, 1, 2, 2, 0, 0, 100));        // wholly inside
    send_request(mk(CoordMin, CoordMin, CoordMax, CoordMax, 0, 0, 0));
    send_request(mk(CoordMin, CoordMax, CoordMax, CoordMin, CoordMax, CoordMax, CoordMax));
    send_request(mk(CoordMax, CoordMax, CoordMax, CoordMax, CoordMin, CoordMin, CoordMax));
    send_request(mk(CoordMin, CoordMin, CoordMin, CoordMax, CoordMax, 0, CoordMax));
    send_request(mk(CoordMax, CoordMin, CoordMin, CoordMax, 0, 0, CoordMax));
    send_request(mk(0, 0, CoordMax, 0, CoordMin, CoordMin, CoordMax));
    send_request(mk(CoordMin, 0, CoordMax, 0, 0, -CoordMax, CoordMax));
    send_request(mk(CoordMin, 0, CoordMax, 0, 0, CoordMin, CoordMax));
  endtask

  // Main sequence
  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();
    s_tvalid <= 1'b0;

    // receiver holds off while the sender keeps offering back to back
    @(posedge clk_i);
    rx_hold_req = 1'b1;
    @(negedge clk_i);
    tx_idle_pct = 0;
    repeat (PressureCount) send_request(random_request());
    tx_idle_pct = IdlePct;
    s_tvalid <= 1'b0;
    wait_drained();

    for (int i = 0; i < RequestCount; i++) begin
      if (i == CalmFirst) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      if (i == CalmLast) begin
        tx_idle_pct = IdlePct;
        rx_idle_pct = IdlePct;
      end
      send_request(random_request());
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
